// ----- rtl/core/pfc_pkg.sv -----
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int SIDE       = 5;
  localparam int CELLS      = SIDE * SIDE;
  localparam int CODE_W     = 5;
  localparam int POS_W      = 3;
  localparam int CFG_W      = 50;
  localparam int CFG_ADDR_W = 2;

  typedef logic [CODE_W-1:0] pfc_code_t;
  typedef logic [POS_W-1:0]  pfc_pos_t;
  typedef logic [CELLS-1:0][CODE_W-1:0] pfc_square_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CELLS_LO  = 2'd0,
    REG_CELLS_MID = 2'd1,
    REG_CELLS_HI  = 2'd2
  } pfc_reg_t;

  localparam logic [49:0] RST_CELLS_LO  = 50'd179255564896711;
  localparam logic [49:0] RST_CELLS_MID = 50'd688896091761926;
  localparam logic [24:0] RST_CELLS_HI  = 25'd26991284;

  localparam pfc_pos_t POS_LAST = pfc_pos_t'(SIDE - 1);

  // where one letter sits in the square
  typedef struct packed {
    logic     found;
    pfc_pos_t row;
    pfc_pos_t col;
  } pfc_loc_t;

  // wrap one step forward or back within a row or column
  function automatic pfc_pos_t pos_step(pfc_pos_t p, logic back);
    pfc_pos_t q;
    if (back) q = (p == '0) ? POS_LAST : p - pfc_pos_t'(1);
    else      q = (p == POS_LAST) ? '0 : p + pfc_pos_t'(1);
    return q;
  endfunction

  function automatic pfc_code_t cell_at(pfc_square_t sq, pfc_pos_t row, pfc_pos_t col);
    logic [CODE_W-1:0] idx;
    idx = CODE_W'(row) * CODE_W'(SIDE) + CODE_W'(col);
    return sq[idx];
  endfunction

endpackage

// ----- rtl/core/pfc_if.sv -----
`timescale 1ns / 1ps
interface pfc_in_if;
  import pfc_pkg::*;
  logic      valid;
  logic      ready;
  logic      func;
  pfc_code_t first_letter;
  pfc_code_t second_letter;
  modport source (output valid, func, first_letter, second_letter, input ready);
  modport sink   (input valid, func, first_letter, second_letter, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;
  logic      valid;
  logic      ready;
  pfc_code_t first_out;
  pfc_code_t second_out;
  logic      not_found;
  modport source (output valid, first_out, second_out, not_found, input ready);
  modport sink   (input valid, first_out, second_out, not_found, output ready);
endinterface

// ----- rtl/core/playfair_digraph_cipher.sv -----
`timescale 1ns / 1ps
// Playfair digraph substitution over a 5x5 key square held in three config
// registers (cell 0 in the low bits of register 0, five bits per cell).
// Each accepted digraph passes through a lane stage, then a merge stage:
// the first stage runs two lookup lanes, one per letter, that
// compare against all 25 cells at once and register row and column; the
// second stage merges the two positions into the same-row, same-column or
// rectangle rule, reads the new letters out of the square and registers them.
// Throughput is one digraph per cycle whenever the output is taken.
// A letter missing from the square gives not_found with both letters zero;
// a letter held in more than one cell resolves to the highest cell.
// The square must only be rewritten while no digraph is in flight.
module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  pfc_in_if.sink                in_chan,
  pfc_out_if.source             out_chan
);

  // key square registers
  logic [49:0] cells_lo_r, cells_mid_r;
  logic [24:0] cells_hi_r;
  pfc_square_t square;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_lo_r  <= RST_CELLS_LO;
      cells_mid_r <= RST_CELLS_MID;
      cells_hi_r  <= RST_CELLS_HI;
    end else if (cfg_we) begin
      unique case (pfc_reg_t'(cfg_addr))
        REG_CELLS_LO:  cells_lo_r  <= cfg_data;
        REG_CELLS_MID: cells_mid_r <= cfg_data;
        REG_CELLS_HI:  cells_hi_r  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  assign square = {cells_hi_r, cells_mid_r, cells_lo_r};

  // pipeline control: each stage advances when the one after it has room
  logic s1_v_r, out_v_r;
  logic out_take, s1_take, in_take;

  assign out_take = !out_v_r || out_chan.ready;
  assign s1_take  = !s1_v_r || out_take;
  assign in_chan.ready = s1_take;
  assign in_take  = in_chan.valid && s1_take;

  // lane stage: one lookup lane per letter
  pfc_loc_t loc_a, loc_b;
  pfc_loc_t loc_a_r, loc_b_r;
  logic     func_r;

  pfc_lane u_lane_a (
    .square (square),
    .letter (in_chan.first_letter),
    .loc    (loc_a)
  );

  pfc_lane u_lane_b (
    .square (square),
    .letter (in_chan.second_letter),
    .loc    (loc_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_take) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      loc_a_r <= loc_a;
      loc_b_r <= loc_b;
      func_r  <= in_chan.func;
    end
  end

  // merge stage: apply the digraph rule and read back the square
  pfc_code_t first_nxt, second_nxt;
  logic      nf_nxt;
  pfc_code_t first_r, second_r;
  logic      nf_r;

  pfc_merge u_merge (
    .square     (square),
    .func       (func_r),
    .loc_a      (loc_a_r),
    .loc_b      (loc_b_r),
    .first_out  (first_nxt),
    .second_out (second_nxt),
    .not_found  (nf_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_v_r) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      nf_r     <= nf_nxt;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.first_out  = first_r;
  assign out_chan.second_out = second_r;
  assign out_chan.not_found  = nf_r;

  // checks

  // a transfer always lands in the lane stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> s1_v_r)
    else $error("input transfer lost");

  // a lane result waiting on a stalled output is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_chan.ready |=> s1_v_r && $stable(loc_a_r) && $stable(loc_b_r))
    else $error("lane stage dropped under stall");

  // a missing letter gives zero letters out
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && nf_r |-> first_r == '0 && second_r == '0)
    else $error("not_found with nonzero letters");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_v_r && !out_v_r)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/pfc_lane.sv -----
`timescale 1ns / 1ps
module pfc_lane
  import pfc_pkg::*;
(
  input  pfc_square_t square,
  input  pfc_code_t   letter,
  output pfc_loc_t    loc
);

  // highest-numbered matching cell wins
  always_comb begin
    loc = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (square[r*SIDE + c] == letter) begin
          loc.found = 1'b1;
          loc.row   = pfc_pos_t'(r);
          loc.col   = pfc_pos_t'(c);
        end
      end
    end
  end

endmodule

// ----- rtl/core/pfc_merge.sv -----
`timescale 1ns / 1ps
module pfc_merge
  import pfc_pkg::*;
(
  input  pfc_square_t square,
  input  logic        func,
  input  pfc_loc_t    loc_a,
  input  pfc_loc_t    loc_b,
  output pfc_code_t   first_out,
  output pfc_code_t   second_out,
  output logic        not_found
);

  pfc_pos_t ra, ca, rb, cb;

  always_comb begin
    ra = loc_a.row;
    ca = loc_b.col;
    rb = loc_b.row;
    cb = loc_a.col;
    if (loc_a.row == loc_b.row) begin
      ca = pos_step(loc_a.col, func);
      cb = pos_step(loc_b.col, func);
    end else if (loc_a.col == loc_b.col) begin
      ra = pos_step(loc_a.row, func);
      rb = pos_step(loc_b.row, func);
      ca = loc_a.col;
      cb = loc_b.col;
    end
    not_found  = !(loc_a.found && loc_b.found);
    first_out  = not_found ? '0 : cell_at(square, ra, ca);
    second_out = not_found ? '0 : cell_at(square, rb, cb);
  end

endmodule
